>>> sv/pdc_pkg.sv
package pdc_pkg;

    localparam int ITER_W = 5;
    localparam int ATAN_LEN = 24;

    localparam logic [2:0] CFG_TARGET_X = 3'd0;
    localparam logic [2:0] CFG_TARGET_Y = 3'd1;
    localparam logic [2:0] CFG_MAX_DRIVE = 3'd2;
    localparam logic [2:0] CFG_HEAD_OFS = 3'd3;
    localparam logic [2:0] CFG_TOLERANCE = 3'd4;
    localparam logic [2:0] CFG_USE_PISTON = 3'd5;

    localparam logic [1:0] STAT_RUNNING = 2'd0;
    localparam logic [1:0] STAT_REACHED = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;
    localparam logic [1:0] STAT_IDLE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MAG,
        S_WRAP,
        S_MIX,
        S_SCL_L,
        S_CLP_L,
        S_SCL_R,
        S_CLP_R,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              cstep;
        logic [ITER_W-1:0] iter;
        logic              mag;
        logic              wrap;
        logic              mix;
        logic              scale;
        logic              clampw;
        logic              sel;
        logic              commit;
    } t_cmd;

    typedef struct packed {
        logic wrap_done;
    } t_stat;

    function automatic logic [19:0] atan_val(input logic [ITER_W-1:0] idx);
        logic [19:0] v;
        unique case (idx)
            5'd0: v = 20'd737280;
            5'd1: v = 20'd435242;
            5'd2: v = 20'd229970;
            5'd3: v = 20'd116736;
            5'd4: v = 20'd58595;
            5'd5: v = 20'd29326;
            5'd6: v = 20'd14667;
            5'd7: v = 20'd7334;
            5'd8: v = 20'd3667;
            5'd9: v = 20'd1833;
            5'd10: v = 20'd917;
            5'd11: v = 20'd458;
            5'd12: v = 20'd229;
            5'd13: v = 20'd115;
            5'd14: v = 20'd57;
            5'd15: v = 20'd29;
            5'd16: v = 20'd14;
            5'd17: v = 20'd7;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/point_drive_pd_controller.sv
// Go-to-point PD drive controller for a differential-drive robot.
// The input channel (i_valid/o_ready) carries one control tick: a start flag,
// the robot position and its compass heading. Each accepted tick yields
// exactly one result transfer on the output channel (o_valid/i_ready) with
// the left and right drive values, the piston latch and the run status.
// The goal, drive limit, heading offset, tolerance and piston enable are
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only
// while no tick is in flight, as the block itself leaves this to the user.
// A tick passes through the shared CORDIC rotator (16 steps by default),
// one iteration per cycle, followed by the angle wrap (one subtraction
// per cycle) and one shared scaling multiplier used for both drives in turn.
// One tick is processed at a time; o_ready is high whenever the datapath is
// free, even while the previous result still waits in the output register.
// If the receiver stalls, the finished tick waits until that register frees.
// After reset the configuration takes its default values, the run is idle,
// the piston latch is clear and the block is ready for a tick.
module point_drive_pd_controller #(
    parameter int TICK_MS = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_start_run,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [14:0]        i_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_left_drive,
    output logic signed [14:0] o_right_drive,
    output logic               o_piston_out,
    output logic [1:0]         o_run_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import pdc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pdc_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pdc_dp #(
        .TICK_MS(TICK_MS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start_run   (i_start_run),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_heading     (i_heading),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .o_piston_out  (o_piston_out),
        .o_run_status  (o_run_status)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("Block accepted a tick while one was in flight.");

    a_stopped_drives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_run_status != STAT_RUNNING)) |->
        (o_left_drive == 15'sd0 && o_right_drive == 15'sd0))
        else $error("Nonzero drive reported outside a running tick.");
`endif

endmodule

>>> sv/pdc_ctrl.sv
module pdc_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  pdc_pkg::t_stat i_stat,
    output pdc_pkg::t_cmd  o_cmd
);
    import pdc_pkg::*;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter = r_iter;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd = '0;
        o_cmd.iter = r_iter;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_iter = '0;
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                o_cmd.cstep = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                if (i_stat.wrap_done) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = S_SCL_L;
            end
            S_SCL_L: begin
                o_cmd.scale = 1'b1;
                n_state = S_CLP_L;
            end
            S_CLP_L: begin
                o_cmd.clampw = 1'b1;
                n_state = S_SCL_R;
            end
            S_SCL_R: begin
                o_cmd.scale = 1'b1;
                o_cmd.sel = 1'b1;
                n_state = S_CLP_R;
            end
            S_CLP_R: begin
                o_cmd.clampw = 1'b1;
                o_cmd.sel = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

>>> sv/pdc_dp.sv
module pdc_dp #(
    parameter int TICK_MS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_start_run,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [14:0]         i_heading,
    input  pdc_pkg::t_cmd       i_cmd,
    output pdc_pkg::t_stat      o_stat,
    output logic signed [14:0]  o_left_drive,
    output logic signed [14:0]  o_right_drive,
    output logic                o_piston_out,
    output logic [1:0]          o_run_status
);
    import pdc_pkg::*;

    localparam int TICK_MULT = TICK_MS * 64;
    localparam logic signed [24:0] FINE_180 = 25'sd2949120;
    localparam logic [27:0] RECIP_625 = 28'd219902326;

    logic signed [15:0] r_tx, r_ty, r_hofs;
    logic [13:0]        r_maxd;
    logic [11:0]        r_tol;
    logic               r_usep;

    logic [15:0]        r_pd, r_sd;
    logic signed [15:0] r_ph;
    logic [11:0]        r_tc;
    logic               r_active, r_piston;

    logic               r_start, r_zero;
    logic [14:0]        r_hd;
    logic signed [29:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic [44:0]        r_magp;
    logic [17:0]        r_wrap;
    logic [15:0]        r_d;
    logic signed [27:0] r_sa, r_sb;
    logic [55:0]        r_prod;
    logic               r_neg;
    logic signed [14:0] r_left, r_right;

    logic signed [14:0] r_o_left, r_o_right;
    logic               r_o_piston;
    logic [1:0]         r_o_status;

    logic signed [17:0] dx, dy;
    logic signed [29:0] x0, y0, xs, ys;
    logic signed [24:0] zr, atan_s;
    logic [45:0]        mag_sum;
    logic [15:0]        mag_d;
    logic signed [16:0] bearing;
    logic signed [19:0] wrap0;
    logic signed [15:0] h;
    logic [15:0]        pd_e;
    logic signed [15:0] ph_e;
    logic signed [27:0] base, turn, s_cur, a_cur;
    logic [27:0]        n_cur;
    logic [18:0]        q;
    logic [13:0]        q_cl;
    logic signed [14:0] drv;
    logic               reverse;
    logic [15:0]        sd_e;
    logic [11:0]        tc_e;
    logic               act_e, tmo;
    logic [31:0]        tmo_lhs, tmo_rhs;

    assign reverse = (r_hofs == 16'sd11520);

    always_comb begin
        dx = 18'(r_tx) - 18'(i_pos_x);
        dy = -18'(r_ty) - 18'(i_pos_y);
        x0 = {{4{dx[17]}}, dx, 8'd0};
        y0 = {{4{dy[17]}}, dy, 8'd0};
        xs = r_x >>> i_cmd.iter;
        ys = r_y >>> i_cmd.iter;
        atan_s = 25'(signed'({1'b0, atan_val(i_cmd.iter)}));

        mag_sum = {1'b0, r_magp} + 46'd8388608;
        if (r_zero) begin
            mag_d = '0;
        end else if (mag_sum[45:40] != '0) begin
            mag_d = 16'hFFFF;
        end else begin
            mag_d = mag_sum[39:24];
        end

        zr = r_zero ? 25'sd0 : r_z;
        bearing = 17'((zr + 25'sd128) >>> 8);
        wrap0 = 20'(bearing) + 20'(r_hofs) - 20'(signed'({1'b0, r_hd})) + 20'sd103680;

        h = 16'(signed'({1'b0, r_wrap})) - 16'sd11520;
        pd_e = r_start ? r_d : r_pd;
        ph_e = r_start ? h : r_ph;
        base = 28'sd303 * 28'(signed'({1'b0, r_d})) - 28'sd3 * 28'(signed'({1'b0, pd_e}));
        turn = 28'sd60 * 28'(h) - 28'sd10 * 28'(ph_e);

        s_cur = i_cmd.sel ? r_sb : r_sa;
        a_cur = s_cur[27] ? -s_cur : s_cur;
        n_cur = 28'(a_cur) * 28'd12 + 28'd312;

        q = r_prod[55:37];
        q_cl = (q > 19'(r_maxd)) ? r_maxd : q[13:0];
        drv = (r_neg ^ reverse) ? -15'(signed'({1'b0, q_cl})) : 15'(signed'({1'b0, q_cl}));

        sd_e = r_start ? r_d : r_sd;
        tc_e = r_start ? 12'd0 : r_tc;
        act_e = r_start || r_active;
        tmo_lhs = 32'(tc_e) * 32'(TICK_MULT);
        tmo_rhs = 32'd64000 + 32'(sd_e) * 32'd50;
        tmo = (tc_e == 12'hFFF) || (tmo_lhs > tmo_rhs);
    end

    assign o_stat.wrap_done = (r_wrap < 18'd23040);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0;
            r_ty <= '0;
            r_maxd <= 14'd12288;
            r_hofs <= '0;
            r_tol <= 12'd64;
            r_usep <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_X: r_tx <= i_cfg_data;
                CFG_TARGET_Y: r_ty <= i_cfg_data;
                CFG_MAX_DRIVE: r_maxd <= i_cfg_data[13:0];
                CFG_HEAD_OFS: r_hofs <= i_cfg_data;
                CFG_TOLERANCE: r_tol <= i_cfg_data[11:0];
                CFG_USE_PISTON: r_usep <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_start_run;
            r_hd <= i_heading;
            r_zero <= (dx == 18'sd0) && (dy == 18'sd0);
            if (x0 < 0) begin
                r_z <= (y0 >= 0) ? FINE_180 : -FINE_180;
                r_x <= -x0;
                r_y <= -y0;
            end else begin
                r_z <= '0;
                r_x <= x0;
                r_y <= y0;
            end
        end else if (i_cmd.cstep) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_s;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_s;
            end
        end
        if (i_cmd.mag) begin
            r_magp <= 45'(r_x[28:0]) * 45'd39797;
            r_wrap <= wrap0[17:0];
        end
        if (i_cmd.wrap) begin
            r_d <= mag_d;
            if (r_wrap >= 18'd23040) begin
                r_wrap <= r_wrap - 18'd23040;
            end
        end
        if (i_cmd.mix) begin
            r_sa <= reverse ? base + turn : base - turn;
            r_sb <= reverse ? base - turn : base + turn;
        end
        if (i_cmd.scale) begin
            r_prod <= 56'(n_cur) * 56'(RECIP_625);
            r_neg <= s_cur[27];
        end
        if (i_cmd.clampw) begin
            if (i_cmd.sel) begin
                r_right <= drv;
            end else begin
                r_left <= drv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd <= '0;
            r_ph <= '0;
            r_sd <= '0;
            r_tc <= '0;
            r_active <= 1'b0;
            r_piston <= 1'b0;
        end else if (i_cmd.commit) begin
            r_pd <= pd_e;
            r_ph <= ph_e;
            r_sd <= sd_e;
            r_tc <= tc_e;
            r_active <= act_e;
            if (act_e) begin
                if (tmo || (r_d <= 16'(r_tol))) begin
                    r_active <= 1'b0;
                end else begin
                    if (r_usep && (r_d <= 16'd1152)) begin
                        r_piston <= 1'b1;
                    end
                    r_pd <= r_d;
                    r_ph <= h;
                    if (tc_e != 12'hFFF) begin
                        r_tc <= tc_e + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_left <= '0;
            r_o_right <= '0;
            r_o_piston <= r_piston;
            r_o_status <= STAT_IDLE;
            if (act_e) begin
                if (tmo) begin
                    r_o_status <= STAT_TIMEOUT;
                end else if (r_d <= 16'(r_tol)) begin
                    r_o_status <= STAT_REACHED;
                end else begin
                    r_o_status <= STAT_RUNNING;
                    r_o_left <= r_left;
                    r_o_right <= r_right;
                    r_o_piston <= r_piston || (r_usep && (r_d <= 16'd1152));
                end
            end
        end
    end

    assign o_left_drive = r_o_left;
    assign o_right_drive = r_o_right;
    assign o_piston_out = r_o_piston;
    assign o_run_status = r_o_status;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pdc_pkg::*;

    localparam int TICK_MS = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [14:0] left;
        logic signed [14:0] right;
        logic               piston;
        logic [1:0]         status;
    } t_drive;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_start_run = 1'b0;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic [14:0] i_heading = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [14:0] o_left_drive;
    logic signed [14:0] o_right_drive;
    logic o_piston_out;
    logic [1:0] o_run_status;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    point_drive_pd_controller #(.TICK_MS(TICK_MS), .CORDIC_STEPS(CORDIC_STEPS)) u_top (.*);

    // Predictor state and configuration.
    longint tgt_x, tgt_y, drv_max, head_ofs, tol;
    bit piston_en;
    longint last_dist, last_head, run_dist;
    int ticks;
    bit running, piston_hold;

    t_drive expected_drives[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_rx = 1'b0;
    bit tx_gaps = 1'b1;

    function automatic longint shr(longint v, int s);
        return v < 0 ? -1 - ((-1 - v) >>> s) : v >>> s;
    endfunction

    function automatic longint atan_step(int i);
        longint t[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                          3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
        return t[i];
    endfunction

    function automatic longint drive_of(longint s);
        longint a, q;
        a = s < 0 ? -s : s;
        q = (a * 12 + 312) / 625;
        if (q > drv_max) q = drv_max;
        return s < 0 ? -q : q;
    endfunction

    task automatic predict_drive(bit st, longint px, longint py, longint hd);
        longint dx, dy, x, y, nx, z, mag, e, r, h, base, turn, lft, rgt;
        t_drive res;
        dx = tgt_x - px;
        dy = -tgt_y - py;
        mag = 0;
        z = 0;
        lft = 0;
        rgt = 0;
        res.status = STAT_IDLE;
        if (dx != 0 || dy != 0) begin
            x = dx * 256;
            y = dy * 256;
            if (x < 0) begin
                z = (y >= 0) ? 2949120 : -2949120;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                if (y >= 0) begin
                    nx = x + shr(y, i);
                    y = y - shr(x, i);
                    z += atan_step(i);
                end else begin
                    nx = x - shr(y, i);
                    y = y + shr(x, i);
                    z -= atan_step(i);
                end
                x = nx;
            end
            mag = (x * 39797 + (64'sd1 << 23)) >>> 24;
            if (mag > 65535) mag = 65535;
            if (mag < 0) mag = 0;
        end
        e = shr(z + 128, 8) + head_ofs - hd;
        r = (e + 11520) % 23040;
        if (r < 0) r += 23040;
        h = r - 11520;
        if (st) begin
            last_dist = mag;
            last_head = h;
            run_dist = mag;
            ticks = 0;
            running = 1'b1;
        end
        if (running) begin
            if (ticks >= 4095 || longint'(ticks) * TICK_MS * 64 > 64000 + 50 * run_dist) begin
                running = 1'b0;
                res.status = STAT_TIMEOUT;
            end else if (mag <= tol) begin
                running = 1'b0;
                res.status = STAT_REACHED;
            end else begin
                if (piston_en && mag <= 1152) piston_hold = 1'b1;
                base = 300 * mag + 3 * (mag - last_dist);
                turn = 50 * h + 10 * (h - last_head);
                last_dist = mag;
                last_head = h;
                if (head_ofs == 11520) begin
                    lft = -drive_of(base + turn);
                    rgt = -drive_of(base - turn);
                end else begin
                    lft = drive_of(base - turn);
                    rgt = drive_of(base + turn);
                end
                if (ticks < 4095) ticks++;
                res.status = STAT_RUNNING;
            end
        end
        res.left = lft[14:0];
        res.right = rgt[14:0];
        res.piston = piston_hold;
        expected_drives.push_back(res);
    endtask

    task automatic send_tick(bit st, logic signed [15:0] px, logic signed [15:0] py,
                             logic [14:0] hd);
        if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_run <= st;
        i_pos_x <= px;
        i_pos_y <= py;
        i_heading <= hd;
        do @(posedge i_clk); while (!o_ready);
        predict_drive(st, px, py, hd);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_drives.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            CFG_TARGET_X: tgt_x = longint'(signed'(val));
            CFG_TARGET_Y: tgt_y = longint'(signed'(val));
            CFG_MAX_DRIVE: drv_max = val[13:0];
            CFG_HEAD_OFS: head_ofs = longint'(signed'(val));
            CFG_TOLERANCE: tol = val[11:0];
            CFG_USE_PISTON: piston_en = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] tx, logic [15:0] ty, logic [15:0] md,
                              logic [15:0] ho, logic [15:0] tl, logic [15:0] up);
        wait_drained();
        write_reg(CFG_TARGET_X, tx);
        write_reg(CFG_TARGET_Y, ty);
        write_reg(CFG_MAX_DRIVE, md);
        write_reg(CFG_HEAD_OFS, ho);
        write_reg(CFG_TOLERANCE, tl);
        write_reg(CFG_USE_PISTON, up);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_tick(bit st);
        send_tick(st, 16'($urandom), 16'($urandom), 15'($urandom_range(0, 32767)));
    endtask

    // A run that approaches the goal so arrival, piston and timeout are reached.
    task automatic approach_run(int steps);
        int px, py, sx, sy;
        px = int'(tgt_x) + $urandom_range(0, 8000) - 4000;
        py = -int'(tgt_y) + $urandom_range(0, 8000) - 4000;
        sx = (-int'(tgt_x) - px) / (steps + 1);
        sy = (-int'(tgt_y) + int'(tgt_y) * 0 - py) / (steps + 1);
        sx = (int'(tgt_x) - px) / (steps + 1);
        for (int i = 0; i < steps; i++) begin
            send_tick(i == 0 || $urandom_range(0, 60) == 0, 16'(px), 16'(py),
                      15'($urandom_range(0, 23039)));
            px += sx + $urandom_range(0, 20) - 10;
            py += sy + $urandom_range(0, 20) - 10;
        end
    endtask

    task automatic test_directed();
        send_tick(1'b0, 16'sd0, 16'sd0, 15'd0);
        send_tick(1'b1, 16'sd0, 16'sd0, 15'd0);
        send_tick(1'b1, 16'sd32767, 16'sd32767, 15'd23039);
        send_tick(1'b0, -16'sd32768, -16'sd32768, 15'd32767);
        send_tick(1'b0, 16'sd1000, 16'sd0, 15'd11520);
        send_tick(1'b0, 16'sd500, 16'sd500, 15'd0);
        send_tick(1'b0, 16'sd40, 16'sd0, 15'd100);
        send_tick(1'b0, 16'sd0, 16'sd0, 15'd0);
        set_config(16'h8000, 16'h7FFF, 16'd16383, 16'd11520, 16'd0, 16'd1);
        send_tick(1'b1, 16'sd32767, -16'sd32768, 15'd0);
        send_tick(1'b0, 16'sd32767, -16'sd32767, 15'd5000);
        send_tick(1'b0, -16'sd32000, -16'sd32767, 15'd0);
        send_tick(1'b1, -16'sd32700, -16'sd32767, 15'd20000);
        set_config(16'd0, 16'd0, 16'd0, -16'sd23040, 16'd4095, 16'd1);
        send_tick(1'b1, 16'sd3000, 16'sd0, 15'd0);
        send_tick(1'b0, 16'sd1000, 16'sd0, 15'd0);
        send_tick(1'b1, 16'sd5000, 16'sd5000, 15'd0);
        set_config(16'd0, 16'd0, 16'd12288, 16'd23040, 16'd64, 16'd0);
        send_tick(1'b1, 16'sd2000, -16'sd2000, 15'd100);
        send_tick(1'b0, 16'sd1900, -16'sd1900, 15'd200);
    endtask

    task automatic test_timeout();
        set_config(16'd0, 16'd0, 16'd12288, 16'd0, 16'd0, 16'd0);
        send_tick(1'b1, 16'sd10, 16'sd0, 15'd0);
        for (int i = 0; i < 60; i++) send_tick(1'b0, 16'sd10, 16'sd0, 15'(i));
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) random_tick(i == 0);
    endtask

    task automatic test_random(int total);
        int n;
        n = 0;
        while (n < total) begin
            set_config(16'($urandom), 16'($urandom),
                       16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16383) : 12288),
                       16'($urandom_range(0, 2) == 0 ? 11520 : $urandom_range(0, 46080) - 23040),
                       16'($urandom_range(0, 4095)), 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 40; i++) random_tick($urandom_range(0, 5) == 0);
                n += 40;
            end else begin
                approach_run(120);
                n += 120;
            end
        end
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        set_config(16'd100, -16'sd200, 16'd12288, 16'd0, 16'd64, 16'd1);
        approach_run(150);
    endtask

    always @(negedge i_clk) begin
        if (hold_rx) i_ready <= 1'b0;
        else if (quiet) i_ready <= 1'b1;
        else if ($urandom_range(0, 6) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
            i_ready <= 1'b1;
        end else i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_drive got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_left_drive, o_right_drive, o_piston_out, o_run_status};
            if (expected_drives.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_drives.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        tgt_x = 0; tgt_y = 0; drv_max = 12288; head_ofs = 0; tol = 64; piston_en = 0;
        last_dist = 0; last_head = 0; run_dist = 0; ticks = 0;
        running = 0; piston_hold = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_timeout();
        test_backpressure();
        test_random(1650);
        test_no_idle();
        wait_drained();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering ticks.
    initial begin
        wait (hold_req);
        hold_rx = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_rx = 1'b0;
    end
endmodule
